@@ rtl/usd_pkg.sv @@
package usd_pkg;

  // default depth of the queue between classifier and decoder
  localparam int unsigned QueueDepth = 2;

  // field widths of one result
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned SkipW = 8;

  // byte classification constants
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] LeadMin  = 8'hC2;
  localparam logic [7:0] Lead3Min = 8'hE0;
  localparam logic [7:0] Lead4Min = 8'hF0;
  localparam logic [7:0] LeadMax  = 8'hF8;
  localparam logic [5:0] PayMask  = 6'h3F;

  // lower bounds of each sequence length and the top scalar value
  localparam logic [CpW-1:0] Min2      = 21'h00080;
  localparam logic [CpW-1:0] Min3      = 21'h00800;
  localparam logic [CpW-1:0] Min4      = 21'h10000;
  localparam logic [CpW-1:0] MaxScalar = 21'h10FFFF;

  // sequence lengths
  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  // what the classifier decided a byte is
  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_CHAR,
    CLS_CONT,
    CLS_STRAY,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4
  } usd_cls_e;

  // one classified byte as it travels through the queue
  typedef struct packed {
    usd_cls_e   cls;
    logic [7:0] data;
    logic       eos;
  } usd_item_t;

  localparam int unsigned ItemW = $bits(usd_item_t);

  // one decoded result
  typedef struct packed {
    logic [SkipW-1:0] skipped_count;
    logic             string_done;
    logic             has_char;
    logic [LenW-1:0]  seq_length;
    logic [CpW-1:0]   code_point;
  } usd_result_t;

endpackage

@@ rtl/usd_front.sv @@
module usd_front import usd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_data_i,
  input  logic [7:0] data_i,
  input  logic       eos_i,
  output usd_item_t  item_o
);

  logic     mode_q;
  usd_cls_e cls;

  // mode register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // byte classification
  always_comb begin
    if (data_i == 8'h00) begin
      cls = CLS_ZERO;
    end else if (!mode_q || !data_i[7]) begin
      cls = CLS_CHAR;
    end else if ((data_i & ContMask) == ContTag) begin
      cls = CLS_CONT;
    end else if (data_i < LeadMin || data_i >= LeadMax) begin
      cls = CLS_STRAY;
    end else if (data_i >= Lead4Min) begin
      cls = CLS_LEAD4;
    end else if (data_i >= Lead3Min) begin
      cls = CLS_LEAD3;
    end else begin
      cls = CLS_LEAD2;
    end
  end

  assign item_o.cls  = cls;
  assign item_o.data = data_i;
  assign item_o.eos  = eos_i;

endmodule

@@ rtl/usd_fifo.sv @@
module usd_fifo import usd_pkg::*; #(
  parameter int unsigned Width = ItemW,
  parameter int unsigned Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/usd_back.sv @@
module usd_back import usd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  usd_item_t   item_i,
  input  logic        item_valid_i,
  output logic        item_pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output usd_result_t result_o
);

  logic [CpW-1:0]   acc_q, acc_d, acc_ext;
  logic [1:0]       rem_q, rem_d;
  logic [LenW-1:0]  plen_q, plen_d, gathered, add_n;
  logic [SkipW-1:0] skip_q, skip_d, skip_sat;
  logic [SkipW:0]   skip_sum;
  logic             out_valid_q, out_valid_d;
  usd_result_t      result_q, result_d;
  logic             pop, has, done, emit, value_ok;
  logic [CpW-1:0]   cp;
  logic [LenW-1:0]  len;

  assign pop        = item_valid_i && (!out_valid_q || m_ready_i);
  assign item_pop_o = pop;

  assign acc_ext  = {acc_q[CpW-7:0], item_i.data[5:0] & PayMask};
  assign gathered = plen_q - {1'b0, rem_q};

  // range and overlong check of a finished sequence
  always_comb begin
    value_ok = (acc_ext <= MaxScalar);
    if (plen_q >= Len2 && acc_ext < Min2) value_ok = 1'b0;
    if (plen_q >= Len3 && acc_ext < Min3) value_ok = 1'b0;
    if (plen_q >= Len4 && acc_ext < Min4) value_ok = 1'b0;
  end

  // decode step for one classified byte
  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    plen_d = plen_q;
    add_n  = '0;
    has    = 1'b0;
    cp     = '0;
    len    = '0;
    if (item_i.cls == CLS_CONT && rem_q != 2'd0) begin
      acc_d = acc_ext;
      rem_d = rem_q - 2'd1;
      if (rem_q == 2'd1) begin
        acc_d  = '0;
        plen_d = '0;
        if (value_ok) begin
          has = 1'b1;
          cp  = acc_ext;
          len = plen_q;
        end else begin
          add_n = plen_q;
        end
      end else if (item_i.eos) begin
        // string ends inside the sequence, drop gathered bytes
        add_n  = gathered + 3'd1;
        acc_d  = '0;
        rem_d  = 2'd0;
        plen_d = '0;
      end
    end else begin
      // any pending sequence is broken by this byte
      if (rem_q != 2'd0) add_n = gathered;
      acc_d  = '0;
      rem_d  = 2'd0;
      plen_d = '0;
      case (item_i.cls)
        CLS_ZERO: begin
        end
        CLS_CHAR: begin
          has = 1'b1;
          cp  = {{(CpW-8){1'b0}}, item_i.data};
          len = Len1;
        end
        CLS_CONT, CLS_STRAY: begin
          add_n = add_n + 3'd1;
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (item_i.eos) begin
            add_n = add_n + 3'd1;
          end else if (item_i.cls == CLS_LEAD4) begin
            acc_d  = {{(CpW-3){1'b0}}, item_i.data[2:0]};
            rem_d  = 2'd3;
            plen_d = Len4;
          end else if (item_i.cls == CLS_LEAD3) begin
            acc_d  = {{(CpW-4){1'b0}}, item_i.data[3:0]};
            rem_d  = 2'd2;
            plen_d = Len3;
          end else begin
            acc_d  = {{(CpW-5){1'b0}}, item_i.data[4:0]};
            rem_d  = 2'd1;
            plen_d = Len2;
          end
        end
        default: begin
        end
      endcase
    end
    done = (item_i.cls == CLS_ZERO) || item_i.eos;
    emit = has || done;
  end

  // saturating skip count
  assign skip_sum = {1'b0, skip_q} + {{(SkipW-LenW+1){1'b0}}, add_n};
  assign skip_sat = skip_sum[SkipW] ? {SkipW{1'b1}} : skip_sum[SkipW-1:0];

  // output register and skip counter
  always_comb begin
    skip_d      = skip_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && !m_ready_i;
    if (pop) begin
      out_valid_d = emit;
      if (emit) begin
        skip_d                 = '0;
        result_d.code_point    = cp;
        result_d.seq_length    = len;
        result_d.has_char      = has;
        result_d.string_done   = done;
        result_d.skipped_count = skip_sat;
      end else begin
        skip_d = skip_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      rem_q       <= 2'd0;
      plen_q      <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        acc_q  <= acc_d;
        rem_q  <= rem_d;
        plen_q <= plen_d;
        skip_q <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign m_valid_o = out_valid_q;
  assign result_o  = result_q;

  // a pending sequence always has at least one byte gathered
  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != 2'd0 |-> plen_q > {1'b0, rem_q} && plen_q >= Len2)
    else $error("pending length inconsistent with remaining count");

  // an emitted character is in range and has a length
  a_char_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.has_char |->
      result_q.code_point <= MaxScalar && result_q.seq_length != '0)
    else $error("emitted character out of range");

  // a result without character carries no code point or length and marks a string end
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_q.has_char |->
      result_q.string_done && result_q.code_point == '0 && result_q.seq_length == '0)
    else $error("empty result carries data");

  // skip count is cleared once a result is produced
  a_skip_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && emit |=> skip_q == '0)
    else $error("skip count not cleared with result");

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// UTF-8 stream decoder. Takes one byte per cycle on the slave stream while s_axis_tready
// is high (tlast marks the last byte of a string) and returns at most one result per
// byte on the master stream. Sustained rate is one byte per clock cycle with the output
// free. The figure is set by the decode state (accumulator, remaining count, skip
// counter), which the back end updates once per cycle for one queued byte unless the
// output stalls; the classifier in front feeds a short queue, so an output stall backs
// up into the queue before s_axis_tready drops. cfg_data_i selects the mode (1 decodes
// UTF-8, 0 passes each nonzero byte as one character); write it only while idle.
module utf8_stream_decoder import usd_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // mode register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_string
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [20:0] code_point, [23:21] seq_length,
                                      // [31:24] skipped_count
  output logic        m_axis_tlast,   // string_done
  output logic        m_axis_tuser    // has_char
);

  usd_item_t   front_item, head_item;
  logic [ItemW-1:0] head_bits;
  logic        q_full, q_valid, q_pop;
  usd_result_t result;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;

  // classifier and mode register
  usd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .data_i      (s_axis_tdata),
    .eos_i       (s_axis_tlast),
    .item_o      (front_item)
  );

  // queue of classified bytes
  usd_fifo #(
    .Width (ItemW),
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .wdata_i (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (head_bits),
    .valid_o (q_valid)
  );

  assign head_item = usd_item_t'(head_bits);

  // decode state and output register
  usd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .item_valid_i (q_valid),
    .item_pop_o   (q_pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .result_o     (result)
  );

  assign m_axis_tdata = {result.skipped_count, result.seq_length, result.code_point};
  assign m_axis_tlast = result.string_done;
  assign m_axis_tuser = result.has_char;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench import usd_pkg::*; ();

  localparam int unsigned IdleLimit = 500;
  localparam int unsigned PerPhase  = 205;
  localparam int unsigned NumPhases = 8;
  localparam bit PhaseMode [NumPhases] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  // tracks the decoder state and the results it owes
  class utf8_decode_tracker;
    usd_result_t due_codes[$];
    bit [30:0]   cp_acc;
    bit [2:0]    cont_left;
    bit [2:0]    seq_len;
    bit [7:0]    drop_cnt;
    bit          utf8_on;
    int          mismatches;

    function void set_mode(bit m);
      utf8_on = m;
    endfunction

    function void count_drops(int unsigned n);
      int unsigned s;
      s = drop_cnt + n;
      drop_cnt = (s > 255) ? 8'd255 : s[7:0];
    endfunction

    // gathered bytes of a pending sequence are lost
    function void drop_pending();
      if (cont_left != 0 && seq_len >= cont_left) count_drops(seq_len - cont_left);
      cont_left = '0;
      seq_len   = '0;
      cp_acc    = '0;
    endfunction

    function bit scalar_ok(bit [30:0] v, bit [2:0] n);
      if (n >= Len2 && v < Min2) return 1'b0;
      if (n >= Len3 && v < Min3) return 1'b0;
      if (n >= Len4 && v < Min4) return 1'b0;
      return v <= MaxScalar;
    endfunction

    // one accepted byte request
    function void take_byte(logic [7:0] b, logic last);
      usd_result_t r;
      bit [2:0]    n;
      r = '0;
      if (!utf8_on) begin
        drop_pending();
        if (b == 8'h00) begin
          r.string_done = 1'b1;
        end else begin
          r.has_char    = 1'b1;
          r.code_point  = 21'(b);
          r.seq_length  = Len1;
          r.string_done = last;
        end
      end else begin
        if (cont_left != 0 && (b & ContMask) == ContTag) begin
          cp_acc = {cp_acc[24:0], b[5:0]};
          cont_left--;
          if (cont_left == 0) begin
            n = seq_len;
            seq_len = '0;
            if (scalar_ok(cp_acc, n)) begin
              r.has_char   = 1'b1;
              r.code_point = cp_acc[20:0];
              r.seq_length = n;
            end else begin
              count_drops(n);
            end
            cp_acc = '0;
          end
        end else begin
          drop_pending();
          if (b != 8'h00) begin
            if (b < ContTag) begin
              r.has_char   = 1'b1;
              r.code_point = 21'(b);
              r.seq_length = Len1;
            end else if (b < LeadMin || b >= LeadMax) begin
              count_drops(1);
            end else begin
              n = (b >= Lead4Min) ? Len4 : (b >= Lead3Min) ? Len3 : Len2;
              cp_acc    = 31'(b & (8'h7F >> n));
              seq_len   = n;
              cont_left = n - 3'd1;
            end
          end
        end
        if (b == 8'h00 || last) begin
          drop_pending();
          r.string_done = 1'b1;
        end
      end
      if (r.has_char || r.string_done) begin
        r.skipped_count = drop_cnt;
        due_codes.push_back(r);
        drop_cnt = '0;
      end
    endfunction

    function void report(string what, usd_result_t want, usd_result_t got);
      if (mismatches < 10) begin
        $display("%0t mismatch (%s): want cp=%h len=%0d char=%0b done=%0b skip=%0d", $realtime,
                 what, want.code_point, want.seq_length, want.has_char, want.string_done,
                 want.skipped_count);
        $display("    got  cp=%h len=%0d char=%0b done=%0b skip=%0d", got.code_point,
                 got.seq_length, got.has_char, got.string_done, got.skipped_count);
      end
      mismatches++;
    endfunction

    // one accepted result
    function void check_result(usd_result_t got);
      usd_result_t want;
      if (due_codes.size() == 0) begin
        report("no result due", '0, got);
        return;
      end
      want = due_codes.pop_front();
      if (got.code_point !== want.code_point || got.seq_length !== want.seq_length ||
          got.has_char !== want.has_char || got.string_done !== want.string_done ||
          got.skipped_count !== want.skipped_count) begin
        report("field differs", want, got);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0;    // end_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;            // [20:0] code_point, [23:21] seq_length,
                                        // [31:24] skipped_count
  logic        m_axis_tlast;            // string_done
  logic        m_axis_tuser;            // has_char

  utf8_decode_tracker tracker = new();
  bit                 calm;
  int unsigned        sent;
  logic [7:0]         word_bytes[$];

  utf8_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(6, 0);
  endfunction

  // byte request, waits out a random gap first
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_byte(b, last);
    sent++;
  endtask

  // stop sending until every owed result is out, then let the pipe settle
  task automatic wait_drained(input int tail);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.due_codes.size() != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_mode(m);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned range_lo(int n);
    case (n)
      1:       return 1;
      2:       return 'h80;
      3:       return 'h800;
      default: return 'h10000;
    endcase
  endfunction

  function automatic int unsigned range_hi(int n);
    case (n)
      1:       return 'h7F;
      2:       return 'h7FF;
      3:       return 'hFFFF;
      default: return 'h10FFFF;
    endcase
  endfunction

  // n-byte form of v, whether or not that form is the shortest
  function automatic void put_utf8(logic [20:0] v, int n);
    case (n)
      1: word_bytes.push_back({1'b0, v[6:0]});
      2: begin
        word_bytes.push_back({3'b110, v[10:6]});
        word_bytes.push_back({2'b10, v[5:0]});
      end
      3: begin
        word_bytes.push_back({4'b1110, v[15:12]});
        word_bytes.push_back({2'b10, v[11:6]});
        word_bytes.push_back({2'b10, v[5:0]});
      end
      default: begin
        word_bytes.push_back({5'b11110, v[20:18]});
        word_bytes.push_back({2'b10, v[17:12]});
        word_bytes.push_back({2'b10, v[11:6]});
        word_bytes.push_back({2'b10, v[5:0]});
      end
    endcase
  endfunction

  // next group of bytes: mostly well formed characters, some broken ones and noise
  function automatic void build_word(bit utf8);
    int          pick;
    int          n;
    int          k;
    logic [20:0] v;
    word_bytes.delete();
    pick = $urandom_range(99, 0);
    if (!utf8) begin
      word_bytes.push_back(8'($urandom_range(255, 0)));
      return;
    end
    n = $urandom_range(4, 1);
    if (pick < 62) begin
      k = $urandom_range(7, 0);
      v = (k == 0) ? 21'(range_lo(n)) : (k == 1) ? 21'(range_hi(n)) :
          21'($urandom_range(range_hi(n), range_lo(n)));
      put_utf8(v, n);
    end else if (pick < 70) begin
      // sequence cut short
      n = $urandom_range(4, 2);
      put_utf8(21'($urandom_range(range_hi(n), range_lo(n))), n);
      k = $urandom_range(n - 1, 1);
      repeat (k) void'(word_bytes.pop_back());
    end else if (pick < 76) begin
      // overlong form
      n = $urandom_range(4, 2);
      put_utf8(21'($urandom_range(range_lo(n) - 1, 0)), n);
    end else if (pick < 80) begin
      // above the top scalar value
      put_utf8(21'($urandom_range('h1FFFFF, 'h110000)), 4);
    end else if (pick < 84) begin
      // lead bytes F8 to FF with up to five trailing continuation bytes
      word_bytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
      repeat ($urandom_range(5, 0)) word_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
    end else if (pick < 88) begin
      word_bytes.push_back(8'h00);
    end else begin
      word_bytes.push_back(8'($urandom_range(255, 1)));
    end
  endfunction

  // result side with random stalls
  initial begin
    int          stall;
    usd_result_t got;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.code_point    = m_axis_tdata[20:0];
        got.seq_length    = m_axis_tdata[23:21];
        got.skipped_count = m_axis_tdata[31:24];
        got.string_done   = m_axis_tlast;
        got.has_char      = m_axis_tuser;
        tracker.check_result(got);
        stall = draw_gap();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request moving anywhere
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned start;
    bit          held;
    bit          ends_here;
    calm = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through mode out of reset: terminator, top byte, byte 80 with end flag
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);

    wait_drained(8);
    write_mode(1'b1);
    // ascii, smallest two-byte value, top scalar value accepted
    send_byte(8'h41, 1'b0);
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    // just above the top scalar value, then an overlong three-byte form
    send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    // stray, five-byte lead, broken sequence
    send_byte(8'hC1, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h41, 1'b0);
    // character finishing on the end flag, terminator inside a sequence
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b1);
    send_byte(8'hE2, 1'b0); send_byte(8'h00, 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained(8);
      write_mode(PhaseMode[p]);
      if (p == 2) begin
        // long run of strays drives the drop counter into saturation
        repeat (270) send_byte(8'($urandom_range(8'hC1, 8'h80)), 1'b0);
        send_byte(8'h7E, 1'b0);
      end
      start = sent;
      held  = 1'b0;
      while (sent - start < PerPhase) begin
        if (!held && sent - start >= PerPhase / 2) begin
          wait_drained(0);
          held = 1'b1;
        end
        build_word(PhaseMode[p]);
        ends_here = ($urandom_range(15, 0) == 0);
        foreach (word_bytes[i]) begin
          send_byte(word_bytes[i], (ends_here && i == word_bytes.size() - 1) ||
                                   ($urandom_range(63, 0) == 0));
        end
        if ($urandom_range(39, 0) == 0) calm = !calm;
      end
    end

    wait_drained(8);
    if (tracker.due_codes.size() != 0) begin
      $display("%0d results never arrived", tracker.due_codes.size());
    end
    if (tracker.mismatches == 0 && tracker.due_codes.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
